FILE: rtl/region_adjacency_builder_core_macros.svh
// Assertion macros shared by the checker of the region adjacency builder.
`ifndef REGION_ADJACENCY_BUILDER_CORE_MACROS_SVH
`define REGION_ADJACENCY_BUILDER_CORE_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off during reset.
`define RAB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent assertion that also holds while reset is asserted.
`define RAB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rab_pkg.sv
// Types and constants shared by the region adjacency builder modules.
package rab_pkg;

	localparam int LABEL_W = 16;
	localparam int OUT_W   = 10;
	localparam int CMP_W   = 16;

	localparam logic CFG_IMAGE_WIDTH = 1'b0;
	localparam logic CFG_LABEL_COUNT = 1'b1;

	localparam logic [10:0] IMAGE_WIDTH_RST = 11'd640;
	localparam logic [10:0] LABEL_COUNT_RST = 11'd1024;

	typedef struct packed {
		logic               clear;
		logic               pairs;
		logic [LABEL_W-1:0] src;
		logic [LABEL_W-1:0] dst0;
		logic [LABEL_W-1:0] dst1;
		logic [LABEL_W-1:0] dst2;
	} job_t;

	typedef enum logic {
		F_IDLE,
		F_WORK
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_CHECK,
		B_READ,
		B_DECIDE,
		B_WRDST,
		B_EMIT
	} back_state_t;

endpackage

FILE: rtl/rab_queue.sv
// Two-entry request queue between the front and the back of the builder.
module rab_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rab_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output rab_pkg::job_t pop_job,
	output logic          empty
);

	rab_pkg::job_t slot_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign pop_job = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/rab_front.sv
// Front of the builder: line buffer, raster position and pair request forming.
module rab_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rab_pkg::LABEL_W-1:0] in_label,
	input  logic                        in_frame_start,
	input  logic [10:0]                 image_width,
	output logic                        push,
	output rab_pkg::job_t               job,
	input  logic                        full
);

	localparam int CLW = $clog2(MAX_WIDTH);

	rab_pkg::front_state_t       state_q, state_d;
	logic [rab_pkg::LABEL_W-1:0] row_mem [MAX_WIDTH];
	logic [rab_pkg::LABEL_W-1:0] up_s1;
	logic [CLW-1:0]              col_s1;
	logic [rab_pkg::LABEL_W-1:0] label_q;
	logic                        fs_q;
	logic [rab_pkg::LABEL_W-1:0] left_q;
	logic [rab_pkg::LABEL_W-1:0] upleft_q;
	logic [CLW-1:0]              column_q;
	logic                        past_q;

	logic                        acc;
	logic [CLW-1:0]              rd_addr;
	logic                        past_eff;
	logic                        need_pairs;
	logic                        need_job;
	logic                        do_upd;
	logic [rab_pkg::CMP_W-1:0]   width_eff;
	logic [rab_pkg::CMP_W-1:0]   col_next;

	assign acc     = in_valid && in_ready;
	assign rd_addr = in_frame_start ? '0 : column_q;

	always_comb begin
		if (image_width < 11'd2) begin
			width_eff = rab_pkg::CMP_W'(2);
		end else if (rab_pkg::CMP_W'(image_width) > rab_pkg::CMP_W'(MAX_WIDTH)) begin
			width_eff = rab_pkg::CMP_W'(MAX_WIDTH);
		end else begin
			width_eff = rab_pkg::CMP_W'(image_width);
		end
	end

	// A frame start restarts the raster at row 0, column 0.
	assign past_eff   = fs_q ? 1'b0 : past_q;
	assign need_pairs = past_eff && (col_s1 != '0);
	assign need_job   = need_pairs || fs_q;
	assign col_next   = rab_pkg::CMP_W'(col_s1) + rab_pkg::CMP_W'(1);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		do_upd   = 1'b0;
		case (state_q)
			rab_pkg::F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = rab_pkg::F_WORK;
				end
			end
			rab_pkg::F_WORK: begin
				if (!need_job || !full) begin
					do_upd  = 1'b1;
					state_d = rab_pkg::F_IDLE;
				end
			end
			default: state_d = rab_pkg::F_IDLE;
		endcase
	end

	assign push     = do_upd && need_job;
	assign job      = '{clear: fs_q, pairs: need_pairs, src: upleft_q,
	                    dst0: up_s1, dst1: left_q, dst2: label_q};

	always_ff @(posedge clk) begin
		if (acc) begin
			up_s1   <= row_mem[rd_addr];
			col_s1  <= rd_addr;
			label_q <= in_label;
			fs_q    <= in_frame_start;
		end
		if (do_upd) begin
			row_mem[col_s1] <= label_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rab_pkg::F_IDLE;
			left_q   <= '0;
			upleft_q <= '0;
			column_q <= '0;
			past_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_upd) begin
				upleft_q <= up_s1;
				left_q   <= label_q;
				if (col_next >= width_eff) begin
					column_q <= '0;
					past_q   <= 1'b1;
				end else begin
					column_q <= col_next[CLW-1:0];
					past_q   <= past_eff;
				end
			end
		end
	end

endmodule

FILE: rtl/rab_back.sv
// Back of the builder: neighbor rows in memory, pair tests and edge output.
module rab_back #(
	parameter int MAX_LABELS    = 1024,
	parameter int MAX_NEIGHBORS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_valid,
	input  rab_pkg::job_t             job,
	output logic                      pop,
	input  logic [10:0]               label_count,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rab_pkg::OUT_W-1:0] out_first,
	output logic [rab_pkg::OUT_W-1:0] out_second,
	output logic                      out_last
);

	localparam int LW = $clog2(MAX_LABELS);
	localparam int CW = $clog2(MAX_NEIGHBORS + 1);
	localparam int RW = MAX_NEIGHBORS * LW + CW;
	localparam int BW = rab_pkg::LABEL_W + 1;

	// One row per label: neighbor count in the low bits, then the list.
	logic [RW-1:0] row_mem [MAX_LABELS];
	logic [RW-1:0] rs_q;
	logic [RW-1:0] rd_q;

	rab_pkg::back_state_t        state_q, state_d;
	rab_pkg::job_t               job_q;
	logic                        go_pairs_q;
	logic [LW-1:0]               clr_q;
	logic [1:0]                  pair_q;
	logic [1:0]                  res_n_q;
	logic [1:0]                  emit_q;
	logic [rab_pkg::OUT_W-1:0]   res_first_q  [3];
	logic [rab_pkg::OUT_W-1:0]   res_second_q [3];
	logic                        out_valid_q;
	logic [rab_pkg::OUT_W-1:0]   out_first_q;
	logic [rab_pkg::OUT_W-1:0]   out_second_q;
	logic                        out_last_q;

	logic [BW-1:0]               bound;
	logic [rab_pkg::LABEL_W-1:0] dst;
	logic                        pair_ok;
	logic [CW-1:0]               cnt_s;
	logic [CW-1:0]               cnt_d;
	logic                        listed;
	logic                        edge_ok;
	logic [RW-1:0]               new_s;
	logic [RW-1:0]               new_d;
	logic                        we;
	logic [LW-1:0]               wa;
	logic [RW-1:0]               wd;
	logic                        re;
	logic                        advance;
	logic                        add_res;
	logic                        load_out;
	logic                        clr_done;
	logic                        emit_last;

	assign bound = (BW'(label_count) > BW'(MAX_LABELS)) ? BW'(MAX_LABELS) : BW'(label_count);

	always_comb begin
		case (pair_q)
			2'd0:    dst = job_q.dst0;
			2'd1:    dst = job_q.dst1;
			default: dst = job_q.dst2;
		endcase
	end

	assign pair_ok = (BW'(job_q.src) < bound) && (BW'(dst) < bound) && (job_q.src != dst);
	assign cnt_s   = rs_q[CW-1:0];
	assign cnt_d   = rd_q[CW-1:0];

	always_comb begin
		listed = 1'b0;
		new_s  = rs_q;
		new_d  = rd_q;
		for (int t = 0; t < MAX_NEIGHBORS; t++) begin
			if ((CW'(t) < cnt_s) && (rs_q[CW + t*LW +: LW] == dst[LW-1:0])) begin
				listed = 1'b1;
			end
			if ((CW'(t) < cnt_d) && (rd_q[CW + t*LW +: LW] == job_q.src[LW-1:0])) begin
				listed = 1'b1;
			end
			if (CW'(t) == cnt_s) begin
				new_s[CW + t*LW +: LW] = dst[LW-1:0];
			end
			if (CW'(t) == cnt_d) begin
				new_d[CW + t*LW +: LW] = job_q.src[LW-1:0];
			end
		end
		new_s[CW-1:0] = cnt_s + CW'(1);
		new_d[CW-1:0] = cnt_d + CW'(1);
	end

	assign edge_ok   = (cnt_s < CW'(MAX_NEIGHBORS)) && (cnt_d < CW'(MAX_NEIGHBORS)) && !listed;
	assign clr_done  = (clr_q == LW'(MAX_LABELS - 1));
	assign emit_last = (emit_q == res_n_q - 2'd1);

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		we       = 1'b0;
		wa       = job_q.src[LW-1:0];
		wd       = new_s;
		re       = 1'b0;
		advance  = 1'b0;
		add_res  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			rab_pkg::B_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				wd = '0;
				if (clr_done) begin
					state_d = go_pairs_q ? rab_pkg::B_CHECK : rab_pkg::B_IDLE;
				end
			end
			rab_pkg::B_IDLE: begin
				if (job_valid) begin
					pop = 1'b1;
					if (job.clear) begin
						state_d = rab_pkg::B_CLEAR;
					end else if (job.pairs) begin
						state_d = rab_pkg::B_CHECK;
					end
				end
			end
			rab_pkg::B_CHECK: begin
				if (pair_ok) begin
					state_d = rab_pkg::B_READ;
				end else begin
					advance = 1'b1;
				end
			end
			rab_pkg::B_READ: begin
				re      = 1'b1;
				state_d = rab_pkg::B_DECIDE;
			end
			rab_pkg::B_DECIDE: begin
				if (edge_ok) begin
					we      = 1'b1;
					add_res = 1'b1;
					state_d = rab_pkg::B_WRDST;
				end else begin
					advance = 1'b1;
				end
			end
			rab_pkg::B_WRDST: begin
				we      = 1'b1;
				wa      = dst[LW-1:0];
				wd      = new_d;
				advance = 1'b1;
			end
			rab_pkg::B_EMIT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					if (emit_last) begin
						state_d = rab_pkg::B_IDLE;
					end
				end
			end
			default: state_d = rab_pkg::B_IDLE;
		endcase
		// After the lower-right pair the collected edges go out, if any.
		if (advance) begin
			if (pair_q == 2'd2) begin
				state_d = ((res_n_q != 2'd0) || add_res) ? rab_pkg::B_EMIT : rab_pkg::B_IDLE;
			end else begin
				state_d = rab_pkg::B_CHECK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			row_mem[wa] <= wd;
		end
		if (re) begin
			rs_q <= row_mem[job_q.src[LW-1:0]];
			rd_q <= row_mem[dst[LW-1:0]];
		end
		if (pop) begin
			job_q <= job;
		end
		if (add_res) begin
			res_first_q[res_n_q]  <= job_q.src[rab_pkg::OUT_W-1:0];
			res_second_q[res_n_q] <= dst[rab_pkg::OUT_W-1:0];
		end
		if (load_out) begin
			out_first_q  <= res_first_q[emit_q];
			out_second_q <= res_second_q[emit_q];
			out_last_q   <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rab_pkg::B_CLEAR;
			go_pairs_q  <= 1'b0;
			clr_q       <= '0;
			pair_q      <= 2'd0;
			res_n_q     <= 2'd0;
			emit_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rab_pkg::B_CLEAR) begin
				clr_q <= clr_done ? '0 : clr_q + LW'(1);
			end
			if (pop) begin
				go_pairs_q <= job.pairs;
				pair_q     <= 2'd0;
				res_n_q    <= 2'd0;
				emit_q     <= 2'd0;
			end
			if (advance) begin
				pair_q <= pair_q + 2'd1;
			end
			if (add_res) begin
				res_n_q <= res_n_q + 2'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				emit_q      <= emit_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_first  = out_first_q;
	assign out_second = out_second_q;
	assign out_last   = out_last_q;

endmodule

FILE: rtl/region_adjacency_builder_core.sv
// Top level of the region adjacency builder: config registers, front, queue, back.
//
// The block reads a label map in raster order, one label per request on the
// s_axis channel (tdata = label, tuser = frame start), and reports every new
// pair of touching labels on the m_axis channel (tdata = first and second label,
// tlast = final edge caused by that input request). The cfg channel writes
// image_width (index 0) and label_count (index 1); it is always ready and must
// only be used while the block is idle.
// The front does not take a new request before it is through with the last one:
// it reads its line buffer when it accepts a request, then updates it, and it
// waits while the queue is full if the request forms a job. The back takes one
// job, tests each pair, reads the neighbor memory for a pair that passes, writes
// both neighbor rows for each new edge, then hands out the edges it collected.
// After reset and at each frame start the back clears all MAX_LABELS neighbor
// counts, one row per cycle; the front keeps taking requests until the
// two-entry queue fills.
// When the receiver stalls, the output register holds its result, the back
// waits on it, and the queue and then s_axis_tready back up in turn.
module region_adjacency_builder_core #(
	parameter int MAX_LABELS    = 1024,
	parameter int MAX_WIDTH     = 1024,
	parameter int MAX_NEIGHBORS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] label
	input  logic        s_axis_tuser,  // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [9:0] first_label, [19:10] second_label, zero above
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);

	logic [10:0]               image_width_q;
	logic [10:0]               label_count_q;
	logic                      push;
	logic                      full;
	logic                      pop;
	logic                      empty;
	rab_pkg::job_t             push_job;
	rab_pkg::job_t             pop_job;
	logic [rab_pkg::OUT_W-1:0] first_label;
	logic [rab_pkg::OUT_W-1:0] second_label;

	// Configuration writes take effect at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= rab_pkg::IMAGE_WIDTH_RST;
			label_count_q <= rab_pkg::LABEL_COUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				rab_pkg::CFG_IMAGE_WIDTH: image_width_q <= cfg_data;
				rab_pkg::CFG_LABEL_COUNT: label_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rab_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_label      (s_axis_tdata),
		.in_frame_start(s_axis_tuser),
		.image_width   (image_width_q),
		.push          (push),
		.job           (push_job),
		.full          (full)
	);

	rab_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (full),
		.pop     (pop),
		.pop_job (pop_job),
		.empty   (empty)
	);

	rab_back #(
		.MAX_LABELS   (MAX_LABELS),
		.MAX_NEIGHBORS(MAX_NEIGHBORS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (!empty),
		.job        (pop_job),
		.pop        (pop),
		.label_count(label_count_q),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_first  (first_label),
		.out_second (second_label),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {4'd0, second_label, first_label};

endmodule

FILE: rtl/rab_checker.sv
// Port-level checker for the region adjacency builder and its bind.
`include "region_adjacency_builder_core_macros.svh"

module rab_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        cfg_ready
);

	// A stalled result keeps its payload.
	`RAB_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")
	// An edge never joins a label to itself.
	`RAB_ASSERT(a_no_self, m_axis_tvalid |-> m_axis_tdata[9:0] != m_axis_tdata[19:10], "self edge reported")
	// The front works on one request at a time.
	`RAB_ASSERT(a_front_busy, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken back to back")
	// The padding above the two labels stays zero.
	`RAB_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[23:20] == 4'd0, "tdata padding not zero")
	// The configuration channel never stalls.
	`RAB_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration channel stalled")

endmodule

bind region_adjacency_builder_core rab_checker u_rab_checker (.*);

FILE: verif/region_adjacency_builder_core_test.sv
// Self-checking testbench for the region adjacency builder core.
`timescale 1ns / 100ps

module region_adjacency_builder_core_test;

	localparam int MAX_LABELS    = 1024;
	localparam int MAX_WIDTH     = 1024;
	localparam int MAX_NEIGHBORS = 12;

	// One expected edge on the output stream.
	typedef struct {
		logic [9:0] first_label;
		logic [9:0] second_label;
		logic       last;
	} edge_rec_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [10:0] cfg_data;

	region_adjacency_builder_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Shadow copy of the block's state, updated as each pixel is accepted.
	logic [15:0] prev_row [MAX_WIDTH];
	logic [15:0] left_px;
	logic [15:0] upper_left_px;
	int          col_pos;
	bit          below_top;
	int          adj_count [MAX_LABELS];
	int          adj_list [MAX_LABELS][MAX_NEIGHBORS];
	logic [10:0] width_reg;
	logic [10:0] bound_reg;

	edge_rec_t pending_edges[$];
	int        mismatches;
	bit        stall_out;     // receiver hold-off requested
	int        stall_cycles;
	bit        allow_idle_out;

	function automatic bit adj_known(int a, int b);
		for (int t = 0; t < adj_count[a]; t++)
			if (adj_list[a][t] == b) return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit add_edge(int a, int b, int bound);
		if (a >= bound || b >= bound || a == b) return 1'b0;
		if (adj_count[a] >= MAX_NEIGHBORS || adj_count[b] >= MAX_NEIGHBORS) return 1'b0;
		if (adj_known(a, b) || adj_known(b, a)) return 1'b0;
		adj_list[a][adj_count[a]] = b;
		adj_count[a]++;
		adj_list[b][adj_count[b]] = a;
		adj_count[b]++;
		return 1'b1;
	endfunction

	// Works out the new edges caused by one pixel and queues them.
	task automatic predict_edges(input logic [15:0] lab, input bit fstart);
		int        w;
		int        bound;
		int        c;
		int        src;
		int        dst [3];
		int        n;
		edge_rec_t e;
		logic [15:0] up;
		w = (width_reg < 2) ? 2 : (width_reg > MAX_WIDTH ? MAX_WIDTH : int'(width_reg));
		bound = (bound_reg > MAX_LABELS) ? MAX_LABELS : int'(bound_reg);
		n = 0;
		if (fstart) begin
			foreach (adj_count[i]) adj_count[i] = 0;
			col_pos = 0;
			below_top = 1'b0;
		end
		c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
		up = prev_row[c];
		if (below_top && c >= 1) begin
			src = upper_left_px;
			dst[0] = up;
			dst[1] = left_px;
			dst[2] = lab;
			for (int i = 0; i < 3; i++) begin
				if (add_edge(src, dst[i], bound)) begin
					e.first_label = src[9:0];
					e.second_label = dst[i][9:0];
					e.last = 1'b0;
					pending_edges = {pending_edges, e};
					n++;
				end
			end
			if (n > 0) pending_edges[$].last = 1'b1;
		end
		upper_left_px = up;
		prev_row[c] = lab;
		left_px = lab;
		c++;
		if (c >= w) begin
			c = 0;
			below_top = 1'b1;
		end
		col_pos = c;
	endtask

	// Random gap: mostly short, sometimes long. The input goes idle first.
	task automatic idle_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		s_axis_tvalid <= 1'b0;
		repeat (g) @(posedge clk);
	endtask

	// Offers one pixel and waits until the block accepts it.
	task automatic send_pixel(input logic [15:0] lab, input bit fstart, input bit gaps);
		cfg_valid <= 1'b0;
		if (gaps && $urandom_range(0, 3) == 0) idle_gap();
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= lab;
		s_axis_tuser  <= fstart;
		do @(posedge clk); while (!s_axis_tready);
		predict_edges(lab, fstart);
	endtask

	// Waits for every expected edge, then a margin longer than a neighbor clearing
	// pass, so that work ending without output is finished too.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_edges.size() != 0) @(posedge clk);
		repeat (MAX_LABELS + 64) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [10:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == rab_pkg::CFG_IMAGE_WIDTH) width_reg = val;
		else bound_reg = val;
	endtask

	// Labels drawn from a small pool so that pairs recur and lists fill up.
	function automatic logic [15:0] pick_label(int pool);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 16'($urandom_range(0, 65535));
		if (r == 1) return 16'($urandom_range(1000, 1100));
		return 16'($urandom_range(0, pool));
	endfunction

	// Edges of the fields, label bound and small widths.
	task automatic test_directed();
		write_reg(rab_pkg::CFG_IMAGE_WIDTH, 11'd2);
		write_reg(rab_pkg::CFG_LABEL_COUNT, 11'd1024);
		send_pixel(16'd0, 1'b1, 1'b0);
		send_pixel(16'd1023, 1'b0, 1'b0);
		send_pixel(16'd1, 1'b0, 1'b0);
		send_pixel(16'hFFFF, 1'b0, 1'b0);
		send_pixel(16'd1022, 1'b0, 1'b0);
		send_pixel(16'd1023, 1'b0, 1'b0);
		send_pixel(16'h5555, 1'b0, 1'b0);
		send_pixel(16'hAAAA, 1'b0, 1'b0);
		drain();
		// Width below the minimum behaves as two; zero bound blocks every edge.
		write_reg(rab_pkg::CFG_IMAGE_WIDTH, 11'd0);
		write_reg(rab_pkg::CFG_LABEL_COUNT, 11'd0);
		send_pixel(16'd3, 1'b1, 1'b0);
		send_pixel(16'd4, 1'b0, 1'b0);
		send_pixel(16'd5, 1'b0, 1'b0);
		send_pixel(16'd6, 1'b0, 1'b0);
		drain();
		write_reg(rab_pkg::CFG_LABEL_COUNT, 11'd2047);
		write_reg(rab_pkg::CFG_IMAGE_WIDTH, 11'd3);
		for (int i = 0; i < 9; i++) send_pixel(16'(i), i == 0, 1'b0);
		drain();
	endtask

	// Hub label fills its neighbor list so further pairs are dropped.
	task automatic test_full_lists();
		write_reg(rab_pkg::CFG_IMAGE_WIDTH, 11'd2);
		write_reg(rab_pkg::CFG_LABEL_COUNT, 11'd64);
		send_pixel(16'd0, 1'b1, 1'b1);
		send_pixel(16'd0, 1'b0, 1'b1);
		for (int i = 0; i < 40; i++) begin
			send_pixel(16'd0, 1'b0, 1'b1);
			send_pixel(16'(1 + i % 20), 1'b0, 1'b1);
		end
		drain();
	endtask

	// Random maps over several widths and bounds, including the extremes.
	task automatic test_random_frames(input int n_items);
		int sent;
		int w;
		int pool;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 4))
				0: w = 2;
				1: w = MAX_WIDTH;
				2: w = 2047;
				default: w = $urandom_range(3, 12);
			endcase
			write_reg(rab_pkg::CFG_IMAGE_WIDTH, 11'(w));
			write_reg(rab_pkg::CFG_LABEL_COUNT, ($urandom_range(0, 2) == 0) ?
				11'($urandom_range(1, 2047)) : 11'd1024);
			pool = $urandom_range(3, 30);
			if (w > 64) begin
				for (int i = 0; i < 20; i++) send_pixel(pick_label(pool), i == 0, 1'b1);
				sent += 20;
			end else begin
				for (int i = 0; i < w * $urandom_range(2, 6); i++) begin
					send_pixel(pick_label(pool), i == 0, 1'b1);
					sent++;
				end
			end
			drain();
		end
	endtask

	// Receiver holds off while the sender keeps going, so the input stalls.
	task automatic test_backpressure();
		write_reg(rab_pkg::CFG_IMAGE_WIDTH, 11'd4);
		write_reg(rab_pkg::CFG_LABEL_COUNT, 11'd1024);
		// The frame start clears the neighbor store before the hold-off begins.
		send_pixel(16'($urandom_range(0, 15)), 1'b1, 1'b0);
		drain();
		stall_cycles = 300;
		stall_out = 1'b1;
		for (int i = 1; i < 40; i++) send_pixel(16'($urandom_range(0, 15)), 1'b0, 1'b0);
		// Sender pause until every result has arrived.
		drain();
	endtask

	// Receiver side: random ready, with a long hold-off on request.
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_out) begin
				m_axis_tready <= 1'b0;
				repeat (stall_cycles) @(posedge clk);
				stall_out = 1'b0;
			end
			if (allow_idle_out)
				m_axis_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
			else
				m_axis_tready <= 1'b1;
			if (!m_axis_tready && $urandom_range(0, 30) == 0) begin
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	// Compares each accepted edge with the oldest expectation.
	always @(posedge clk) begin
		edge_rec_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_edges.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected edge %0d-%0d last %0b", m_axis_tdata[9:0],
						m_axis_tdata[19:10], m_axis_tlast);
			end else begin
				e = pending_edges.pop_front();
				if (m_axis_tdata[9:0] !== e.first_label ||
						m_axis_tdata[19:10] !== e.second_label ||
						m_axis_tdata[23:20] !== 4'd0 || m_axis_tlast !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Edge mismatch: expected %0d-%0d last %0b, got %0d-%0d last %0b",
							e.first_label, e.second_label, e.last, m_axis_tdata[9:0],
							m_axis_tdata[19:10], m_axis_tlast);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = rab_pkg::CFG_IMAGE_WIDTH;
		cfg_data = '0;
		mismatches = 0;
		stall_out = 1'b0;
		stall_cycles = 0;
		allow_idle_out = 1'b1;
		width_reg = rab_pkg::IMAGE_WIDTH_RST;
		bound_reg = rab_pkg::LABEL_COUNT_RST;
		left_px = '0;
		upper_left_px = '0;
		col_pos = 0;
		below_top = 1'b0;
		foreach (prev_row[i]) prev_row[i] = '0;
		foreach (adj_count[i]) adj_count[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_lists();
		test_backpressure();
		test_random_frames(360);
		drain();
		if (mismatches == 0 && pending_edges.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
